@@ rtl/column_sort_engine_assert.svh @@
// ----------------------------------------------------------------------------
// column_sort_engine_assert.svh
// Assertion macros used by the column sort engine checker.
// ----------------------------------------------------------------------------
`ifndef COLUMN_SORT_ENGINE_ASSERT_SVH
`define COLUMN_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("column_sort_engine assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("column_sort_engine assertion failed");

`endif

@@ rtl/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// cse_pkg
// Shared constants, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int ROWS_W    = 11;
    localparam int COLS_W    = 6;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd128;
    localparam logic [COLS_W-1:0] COLS_RESET = 6'd8;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SORT  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Datapath operations issued by the controller
    localparam logic [3:0] OP_IDLE      = 4'd0;
    localparam logic [3:0] OP_WRITE     = 4'd1;
    localparam logic [3:0] OP_READ      = 4'd2;
    localparam logic [3:0] OP_RD_OUT    = 4'd3;
    localparam logic [3:0] OP_DIM_INIT  = 4'd4;
    localparam logic [3:0] OP_DIM_STEP  = 4'd5;
    localparam logic [3:0] OP_OUT_BAD   = 4'd6;
    localparam logic [3:0] OP_OUT_OK    = 4'd7;
    localparam logic [3:0] OP_PASS_INIT = 4'd8;
    localparam logic [3:0] OP_RUN_RDI   = 4'd9;
    localparam logic [3:0] OP_RUN_GETV  = 4'd10;
    localparam logic [3:0] OP_RUN_CMP   = 4'd11;
    localparam logic [3:0] OP_RUN_PUT   = 4'd12;
    localparam logic [3:0] OP_RUN_NEXT  = 4'd13;
    localparam logic [3:0] OP_COPY      = 4'd14;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  index;
        logic [31:0] key_in;
    } t_in;

    typedef struct packed {
        logic [31:0] key_out;
        logic        status;
    } t_out;

    typedef struct packed {
        logic [3:0] op;
        logic       buf_sel;   // sort buffer or copy source: 0 key store, 1 transpose
        logic       shift;     // pass works on windows offset by half a column
    } t_ctl;

    typedef struct packed {
        logic out_free;
        logic rem_ge;
        logic dim_ok;
        logic gt;
        logic j_one;
        logic i_last;
        logic run_last;
        logic cnt_last;
        logic one_col;
    } t_sts;

endpackage

@@ rtl/cse_ram.sv @@
// ----------------------------------------------------------------------------
// cse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/cse_ctrl.sv @@
// ----------------------------------------------------------------------------
// cse_ctrl
// Command sequencer: accepts beats, runs the dimension check and the six
// columnsort passes by issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_action,
    input  cse_pkg::t_sts i_sts,
    output cse_pkg::t_ctl o_ctl
);
    import cse_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDW  = 4'd1;
    localparam logic [3:0] ST_DIM  = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_PINI = 4'd4;
    localparam logic [3:0] ST_RDI  = 4'd5;
    localparam logic [3:0] ST_GETV = 4'd6;
    localparam logic [3:0] ST_CMP  = 4'd7;
    localparam logic [3:0] ST_PUT  = 4'd8;
    localparam logic [3:0] ST_RNX  = 4'd9;
    localparam logic [3:0] ST_CP   = 4'd10;
    localparam logic [3:0] ST_CPD  = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    localparam logic [2:0] PH_SORT1  = 3'd0;
    localparam logic [2:0] PH_TRANS  = 3'd1;
    localparam logic [2:0] PH_SORT2  = 3'd2;
    localparam logic [2:0] PH_UNTR   = 3'd3;
    localparam logic [2:0] PH_SHIFT  = 3'd5;

    logic [3:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic       accept;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Next state and operation
    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        o_ctl.op      = OP_IDLE;
        o_ctl.buf_sel = (r_phase == PH_SORT2) || (r_phase == PH_UNTR);
        o_ctl.shift   = (r_phase == PH_SHIFT);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority case (i_action)
                        ACT_WRITE: o_ctl.op = OP_WRITE;
                        ACT_READ: begin
                            o_ctl.op = OP_READ;
                            n_state  = ST_RDW;
                        end
                        ACT_SORT: begin
                            o_ctl.op = OP_DIM_INIT;
                            n_state  = ST_DIM;
                        end
                        default: o_ctl.op = OP_IDLE;
                    endcase
                end
            end
            ST_RDW: begin
                o_ctl.op = OP_RD_OUT;
                n_state  = ST_IDLE;
            end
            ST_DIM: begin
                if (i_sts.rem_ge) begin
                    o_ctl.op = OP_DIM_STEP;
                end else begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.dim_ok) begin
                    n_phase = PH_SORT1;
                    n_state = ST_PINI;
                end else begin
                    o_ctl.op = OP_OUT_BAD;
                    n_state  = ST_IDLE;
                end
            end
            ST_PINI: begin
                o_ctl.op = OP_PASS_INIT;
                if ((r_phase == PH_TRANS) || (r_phase == PH_UNTR)) begin
                    n_state = ST_CP;
                end else if ((r_phase == PH_SHIFT) && i_sts.one_col) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_RDI;
                end
            end
            ST_RDI: begin
                o_ctl.op = OP_RUN_RDI;
                n_state  = ST_GETV;
            end
            ST_GETV: begin
                o_ctl.op = OP_RUN_GETV;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_ctl.op = OP_RUN_CMP;
                if (i_sts.gt) begin
                    if (i_sts.j_one) begin
                        n_state = ST_PUT;
                    end
                end else begin
                    n_state = i_sts.i_last ? ST_RNX : ST_RDI;
                end
            end
            ST_PUT: begin
                o_ctl.op = OP_RUN_PUT;
                n_state  = i_sts.i_last ? ST_RNX : ST_RDI;
            end
            ST_RNX: begin
                if (!i_sts.run_last) begin
                    o_ctl.op = OP_RUN_NEXT;
                    n_state  = ST_RDI;
                end else if (r_phase == PH_SHIFT) begin
                    n_state = ST_FIN;
                end else begin
                    n_phase = r_phase + 3'd1;
                    n_state = ST_PINI;
                end
            end
            ST_CP: begin
                o_ctl.op = OP_COPY;
                if (i_sts.cnt_last) begin
                    n_state = ST_CPD;
                end
            end
            ST_CPD: begin
                n_phase = r_phase + 3'd1;
                n_state = ST_PINI;
            end
            ST_FIN: begin
                o_ctl.op = OP_OUT_OK;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_SORT1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

@@ rtl/cse_datapath.sv @@
// ----------------------------------------------------------------------------
// cse_datapath
// Key store and transpose buffer, dimension check, insertion-sort run
// registers, copy address generator and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cse_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cse_pkg::t_in                  i_in_data,
    input  logic                          i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cse_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  cse_pkg::t_ctl                 i_ctl,
    output cse_pkg::t_sts                 o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output cse_pkg::t_out                 o_out_data
);
    import cse_pkg::*;

    logic [ROWS_W-1:0]    r_rows, r_rem, r_size, r_i, r_j, r_q, r_cnt;
    logic [COLS_W-1:0]    r_cols, r_col, r_run;
    logic [ADDR_W-1:0]    r_base, r_off, r_dw_addr;
    logic [KEY_WIDTH-1:0] r_v;
    logic                 r_buf, r_shift, r_cp_v, r_sq_ok, r_fit, r_ov;
    t_out                 r_out;

    logic [2*COLS_W-1:0]        sq;
    logic [ROWS_W+COLS_W-1:0]   prod;
    logic [ADDR_W-1:0]          a_i, a_im1, a_j, a_jm2, a_tr;
    logic                       ks_we, tb_we;
    logic [ADDR_W-1:0]          ks_wa, tb_wa, ks_ra, tb_ra, s_ra;
    logic [KEY_WIDTH-1:0]       ks_wd, tb_wd, ks_rd, tb_rd, s_rd, c_rd, s_wd;
    logic                       s_we;

    // Memories
    cse_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ITEMS)) u_ks (
        .i_clk(i_clk), .i_we(ks_we), .i_waddr(ks_wa), .i_wdata(ks_wd),
        .i_raddr(ks_ra), .o_rdata(ks_rd)
    );
    cse_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ITEMS)) u_tb (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_wa), .i_wdata(tb_wd),
        .i_raddr(tb_ra), .o_rdata(tb_rd)
    );

    // Dimension products
    assign sq   = (2*COLS_W)'(r_cols) * (2*COLS_W)'(r_cols);
    assign prod = (ROWS_W+COLS_W)'(r_rows) * (ROWS_W+COLS_W)'(r_cols);

    // Sort run and copy addresses
    assign a_i   = r_base + r_i[ADDR_W-1:0];
    assign a_im1 = a_i - ADDR_W'(1);
    assign a_j   = r_base + r_j[ADDR_W-1:0];
    assign a_jm2 = a_j - ADDR_W'(2);
    assign a_tr  = r_off + r_q[ADDR_W-1:0];
    assign s_rd  = r_buf ? tb_rd : ks_rd;
    assign c_rd  = s_rd;

    // Status to the controller
    assign o_sts.out_free = !r_ov || i_out_ready;
    assign o_sts.rem_ge   = (r_cols != '0) && (r_rem >= ROWS_W'(r_cols));
    assign o_sts.dim_ok   = (r_rows != '0) && (r_cols != '0) && !r_rows[0]
                            && (r_rem == '0) && r_sq_ok && r_fit;
    assign o_sts.gt       = s_rd > r_v;
    assign o_sts.j_one    = (r_j == ROWS_W'(1));
    assign o_sts.i_last   = (r_i == r_rows - ROWS_W'(1));
    assign o_sts.run_last = ((COLS_W+1)'(r_run) + (COLS_W+1)'(1) + (COLS_W+1)'(r_shift))
                            == (COLS_W+1)'(r_cols);
    assign o_sts.cnt_last = (r_cnt == r_size - ROWS_W'(1));
    assign o_sts.one_col  = (r_cols == COLS_W'(1));

    // Sort buffer port selection
    always_comb begin
        s_we = 1'b0;
        s_wd = r_v;
        s_ra = a_i;
        unique case (i_ctl.op)
            OP_RUN_GETV: s_ra = a_im1;
            OP_RUN_CMP: begin
                s_we = 1'b1;
                s_wd = o_sts.gt ? s_rd : r_v;
                s_ra = a_jm2;
            end
            OP_RUN_PUT: s_we = 1'b1;
            OP_COPY:    s_ra = r_buf ? a_tr : r_cnt[ADDR_W-1:0];
            default:    s_ra = a_i;
        endcase
    end

    // Memory port steering
    always_comb begin
        ks_we = 1'b0;
        ks_wa = a_j;
        ks_wd = s_wd;
        ks_ra = s_ra;
        tb_we = 1'b0;
        tb_wa = a_j;
        tb_wd = s_wd;
        tb_ra = s_ra;
        if (i_ctl.op == OP_WRITE) begin
            ks_we = 1'b1;
            ks_wa = i_in_data.index;
            ks_wd = i_in_data.key_in;
        end else if (i_ctl.op == OP_READ) begin
            ks_ra = i_in_data.index;
        end else if (r_cp_v) begin
            if (r_buf) begin
                ks_we = 1'b1;
                ks_wa = r_dw_addr;
                ks_wd = c_rd;
            end else begin
                tb_we = 1'b1;
                tb_wa = r_dw_addr;
                tb_wd = c_rd;
            end
        end else if (s_we) begin
            ks_we = !r_buf;
            tb_we = r_buf;
        end
    end

    // Configuration registers and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
            r_ov   <= 1'b0;
            r_cp_v <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_ROWS)) begin
                r_rows <= i_cfg_wdata[ROWS_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == CFG_COLS)) begin
                r_cols <= i_cfg_wdata[COLS_W-1:0];
            end
            r_cp_v <= (i_ctl.op == OP_COPY);
            if ((i_ctl.op == OP_RD_OUT) || (i_ctl.op == OP_OUT_OK)
                || (i_ctl.op == OP_OUT_BAD)) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_dw_addr <= r_buf ? r_cnt[ADDR_W-1:0] : a_tr;
        unique case (i_ctl.op)
            OP_RD_OUT: begin
                r_out.key_out <= ks_rd;
                r_out.status  <= 1'b0;
            end
            OP_OUT_OK: begin
                r_out.key_out <= '0;
                r_out.status  <= 1'b0;
            end
            OP_OUT_BAD: begin
                r_out.key_out <= '0;
                r_out.status  <= 1'b1;
            end
            OP_DIM_INIT: begin
                r_rem   <= r_rows;
                r_sq_ok <= ({2'b00, r_rows} >= {sq, 1'b0});
                r_fit   <= (prod <= (ROWS_W+COLS_W)'(MAX_ITEMS));
                r_size  <= prod[ROWS_W-1:0];
            end
            OP_DIM_STEP: r_rem <= r_rem - ROWS_W'(r_cols);
            OP_PASS_INIT: begin
                r_buf   <= i_ctl.buf_sel;
                r_shift <= i_ctl.shift;
                r_base  <= i_ctl.shift ? r_rows[ADDR_W:1] : '0;
                r_i     <= ROWS_W'(1);
                r_run   <= '0;
                r_cnt   <= '0;
                r_col   <= '0;
                r_q     <= '0;
                r_off   <= '0;
            end
            OP_RUN_GETV: begin
                r_v <= s_rd;
                r_j <= r_i;
            end
            OP_RUN_CMP: begin
                if (o_sts.gt) begin
                    r_j <= r_j - ROWS_W'(1);
                end else begin
                    r_i <= r_i + ROWS_W'(1);
                end
            end
            OP_RUN_PUT: r_i <= r_i + ROWS_W'(1);
            OP_RUN_NEXT: begin
                r_base <= r_base + r_rows[ADDR_W-1:0];
                r_run  <= r_run + COLS_W'(1);
                r_i    <= ROWS_W'(1);
            end
            OP_COPY: begin
                r_cnt <= r_cnt + ROWS_W'(1);
                if (r_col == r_cols - COLS_W'(1)) begin
                    r_col <= '0;
                    r_off <= '0;
                    r_q   <= r_q + ROWS_W'(1);
                end else begin
                    r_col <= r_col + COLS_W'(1);
                    r_off <= r_off + r_rows[ADDR_W-1:0];
                end
            end
            default: r_v <= r_v;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

@@ rtl/column_sort_engine.sv @@
// ----------------------------------------------------------------------------
// column_sort_engine
// Leighton columnsort engine over an r by s key matrix held column-major.
// ----------------------------------------------------------------------------
// A read beat waits on the registered RAM read. A sort beat runs the
// dimension check (repeated subtraction for r mod s), then the insertion-sort
// passes and two copy passes, all through the single read port of each key
// RAM. A sort that fails the dimension check returns status 1 after the
// check. No memory clearing pass runs after reset. Results wait in an
// output register.
`timescale 1ns / 1ps

module column_sort_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cse_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cse_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cse_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import cse_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // Sequencer
    cse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_action(i_in_data.action),
        .i_sts(sts), .o_ctl(ctl)
    );

    // Storage and arithmetic
    cse_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_data(i_in_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_ctl(ctl), .o_sts(sts), .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data)
    );

endmodule

@@ rtl/cse_checker.sv @@
// ----------------------------------------------------------------------------
// cse_checker
// Port-level assertions for the column sort engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "column_sort_engine_assert.svh"

module cse_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input cse_pkg::t_in                  i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input cse_pkg::t_out                 o_out_data,
    input logic                          i_cfg_we,
    input logic [cse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [cse_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import cse_pkg::*;

    logic rd_acc, sort_acc;
    assign rd_acc   = i_in_valid && o_in_ready && (i_in_data.action == ACT_READ);
    assign sort_acc = i_in_valid && o_in_ready && (i_in_data.action == ACT_SORT);

    // Hold off input while a result is stalled
    `CSE_ASSERT_NOW(a_no_take_when_stalled, o_out_valid && !i_out_ready, !o_in_ready)
    // Result stays up until taken
    `CSE_ASSERT_NEXT(a_out_holds, o_out_valid && !i_out_ready, o_out_valid)
    // A read occupies the block while its RAM read completes
    `CSE_ASSERT_NEXT(a_read_busy, rd_acc, !o_in_ready && !o_out_valid)
    // A sort never answers in the next cycle
    `CSE_ASSERT_NEXT(a_sort_busy, sort_acc, !o_in_ready && !o_out_valid)

endmodule

bind column_sort_engine cse_checker u_cse_checker (.*);
